@@ rtl/lsivt_pkg.sv @@
// ============================================================================
// lsivt_pkg
// Shared constants and types for the slope-intercept line voting table.
// ============================================================================
package lsivt_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int COORD_BITS  = 12;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
    localparam int SLOPE_BITS  = 29;
    localparam int ICPT_BITS   = 42;
    localparam int VOTE_BITS   = 16;
    localparam int TOL_BITS    = 12;
    localparam int QUO_BITS    = COORD_BITS + 17;

    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_VOTE   = 2'd1;
    localparam logic [1:0] MODE_REPORT = 2'd2;

    localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(200);

    typedef struct packed {
        logic [SLOPE_BITS-1:0] slope;
        logic [ICPT_BITS-1:0]  icpt;
        logic [VOTE_BITS-1:0]  votes;
    } entry_t;

endpackage

@@ rtl/line_slope_intercept_vote_table.sv @@
// ============================================================================
// line_slope_intercept_vote_table
// Line voting table keyed on slope and intercept of successive edge points.
// ============================================================================
// Usage. Requests arrive on in_valid/in_stall with mode, x and y. Mode 0
// stores a start point; mode 1 forms the segment from the previous point,
// divides dy*65536 by dx and searches the table for a line with the same
// slope and an intercept within the tolerance, adding a vote or appending
// an entry while the table has room. Mode 2 scans the table for the entry with the most votes and
// returns one result on out_valid/out_stall; other modes give no result.
// One request is handled at a time. A vote request occupies the block while
// it loads the bit-serial divider, divides, saturates the slope, forms the
// intercept with a multiply and a subtract, then reads the filled table
// entries in turn until a hit and closes the search. A report occupies the
// block while it reads every filled entry and until its result is loaded.
// Start requests, and vote requests that cast nothing, leave the block
// idle. The result sits in an output register; while the receiver stalls,
// the block keeps taking requests and only a second report waits, holding
// in_stall high, until the register is free. Reset clears the previous
// point, the entry count, the control state and restores the tolerance to
// 200; the table memory itself is not cleared, as only filled entries are
// read. Write the tolerance through cfg_we/cfg_data only while the block
// is idle; the block itself does not enforce this.
// ============================================================================
module line_slope_intercept_vote_table
    import lsivt_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [TOL_BITS-1:0]          cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   mode,
    input  logic [COORD_BITS-1:0]        x,
    input  logic [COORD_BITS-1:0]        y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [SLOPE_BITS-1:0] best_slope,
    output logic signed [ICPT_BITS-1:0]  best_intercept,
    output logic [VOTE_BITS-1:0]         best_votes,
    output logic [6:0]                   best_index,
    output logic                         table_empty
);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_MUL, S_SRCH, S_RPT, S_OUT
    } state_t;

    state_t state_reg;
    logic [TOL_BITS-1:0]   tol_reg;
    logic [COORD_BITS-1:0] last_x_reg, last_y_reg, x_reg, y_reg;
    logic                  have_last_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   ptr_reg;
    logic                  rd_pend_reg;
    logic                  neg_reg;

    // Entry memory.
    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;
    logic   mem_we;
    logic [IDX_BITS-1:0] mem_waddr;
    entry_t mem_wdata;
    logic   mem_re;
    logic [IDX_BITS-1:0] mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    // Segment arithmetic.
    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS-1:0] adx, ady;
    logic div_start, div_done;
    logic [QUO_BITS-1:0] div_q;
    logic signed [SLOPE_BITS-1:0] slope_reg;
    logic signed [ICPT_BITS-1:0]  icpt_reg;
    logic signed [QUO_BITS:0] sq;
    logic signed [SLOPE_BITS-1:0] slope_sat;

    assign dx  = $signed({1'b0, x}) - $signed({1'b0, last_x_reg});
    assign dy  = $signed({1'b0, y}) - $signed({1'b0, last_y_reg});
    assign adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    assign ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];

    lsivt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({1'b0, ady, 16'd0}),
        .divisor  (adx),
        .done     (div_done),
        .quotient (div_q)
    );

    assign sq = neg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    always_comb
    begin
        if (sq > $signed((QUO_BITS+1)'(268435455)))
            slope_sat = SLOPE_BITS'(268435455);
        else if (sq < -$signed((QUO_BITS+1)'(268435456)))
            slope_sat = {1'b1, {(SLOPE_BITS-1){1'b0}}};
        else
            slope_sat = sq[SLOPE_BITS-1:0];
    end

    // Intercept: y*65536 - slope*x, one multiply then a registered subtract.
    logic signed [SLOPE_BITS+COORD_BITS:0] prod_reg;
    logic signed [SLOPE_BITS+COORD_BITS+1:0] ic_full;
    logic signed [ICPT_BITS-1:0] icpt_sat;
    assign ic_full = $signed({1'b0, y_reg, 16'd0}) - prod_reg;
    always_comb
    begin
        if (ic_full > $signed((SLOPE_BITS+COORD_BITS+2)'(64'sd2199023255551)))
            icpt_sat = {1'b0, {(ICPT_BITS-1){1'b1}}};
        else if (ic_full < -$signed((SLOPE_BITS+COORD_BITS+2)'(64'sd2199023255552)))
            icpt_sat = {1'b1, {(ICPT_BITS-1){1'b0}}};
        else
            icpt_sat = ic_full[ICPT_BITS-1:0];
    end

    // Search compare on the entry read in the previous cycle.
    logic signed [ICPT_BITS:0] idiff;
    logic [ICPT_BITS:0] iabs;
    logic hit;
    logic [IDX_BITS-1:0] cmp_idx_reg;
    logic [VOTE_BITS-1:0] best_v_reg;
    logic [IDX_BITS-1:0]  best_i_reg;
    entry_t best_e_reg;
    logic mul_phase_reg;

    assign idiff = $signed({rd_data_reg.icpt[ICPT_BITS-1], rd_data_reg.icpt})
                 - $signed({icpt_reg[ICPT_BITS-1], icpt_reg});
    assign iabs  = idiff[ICPT_BITS] ? (ICPT_BITS+1)'(-idiff) : idiff;
    assign hit   = (rd_data_reg.slope == slope_reg)
                 && (iabs < {{(ICPT_BITS-TOL_BITS-15){1'b0}}, tol_reg, 16'd0});

    // Output register; it is free when empty or being taken this cycle.
    logic [SLOPE_BITS-1:0] out_slope_reg;
    logic [ICPT_BITS-1:0]  out_icpt_reg;
    logic [VOTE_BITS-1:0]  out_votes_reg;
    logic [IDX_BITS-1:0]   out_index_reg;
    logic                  out_empty_reg;
    logic                  out_free;
    logic                  out_load;

    assign out_free = !out_valid || !out_stall;
    assign out_load = (state_reg == S_OUT) && out_free;

    logic accept;
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign div_start = accept && (mode == MODE_VOTE) && have_last_reg && (dx != '0);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cmp_idx_reg;
        mem_wdata = rd_data_reg;
        mem_re    = 1'b0;
        mem_raddr = ptr_reg[IDX_BITS-1:0];
        if (state_reg == S_SRCH)
        begin
            mem_re = (ptr_reg < count_reg);
            if (rd_pend_reg && hit)
            begin
                mem_we = 1'b1;
                if (rd_data_reg.votes != '1)
                    mem_wdata.votes = rd_data_reg.votes + 1'b1;
            end
            else if (!rd_pend_reg && !(ptr_reg < count_reg)
                     && (count_reg < CNT_BITS'(TABLE_DEPTH)))
            begin
                mem_we    = 1'b1;
                mem_waddr = count_reg[IDX_BITS-1:0];
                mem_wdata = '{slope: slope_reg, icpt: icpt_reg, votes: VOTE_BITS'(1)};
            end
        end
        else if (state_reg == S_RPT)
            mem_re = (ptr_reg < count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tol_reg       <= TOL_RESET;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            have_last_reg <= 1'b0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid     <= 1'b0;
            mul_phase_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                tol_reg <= cfg_data;
            if (out_load)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (mode == MODE_START || mode == MODE_VOTE)
                        begin
                            last_x_reg    <= x;
                            last_y_reg    <= y;
                            have_last_reg <= 1'b1;
                            if (div_start)
                                state_reg <= S_DIV;
                        end
                        else if (mode == MODE_REPORT)
                        begin
                            ptr_reg     <= '0;
                            rd_pend_reg <= 1'b0;
                            state_reg   <= S_RPT;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        mul_phase_reg <= 1'b0;
                        state_reg     <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    mul_phase_reg <= 1'b1;
                    if (mul_phase_reg)
                    begin
                        ptr_reg     <= '0;
                        rd_pend_reg <= 1'b0;
                        state_reg   <= S_SRCH;
                    end
                end
                S_SRCH:
                begin
                    if (rd_pend_reg && hit)
                        state_reg <= S_IDLE;
                    else if (ptr_reg < count_reg)
                    begin
                        ptr_reg     <= ptr_reg + 1'b1;
                        rd_pend_reg <= 1'b1;
                    end
                    else if (rd_pend_reg)
                        rd_pend_reg <= 1'b0;
                    else
                    begin
                        if (count_reg < CNT_BITS'(TABLE_DEPTH))
                            count_reg <= count_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_RPT:
                begin
                    if (ptr_reg < count_reg)
                    begin
                        ptr_reg     <= ptr_reg + 1'b1;
                        rd_pend_reg <= 1'b1;
                    end
                    else if (rd_pend_reg)
                        rd_pend_reg <= 1'b0;
                    else
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg   <= x;
            y_reg   <= y;
            neg_reg <= dx[COORD_BITS] ^ dy[COORD_BITS];
        end
        if (state_reg == S_DIV && div_done)
            slope_reg <= slope_sat;
        if (state_reg == S_MUL && !mul_phase_reg)
            prod_reg <= slope_reg * $signed({1'b0, x_reg});
        if (state_reg == S_MUL && mul_phase_reg)
            icpt_reg <= icpt_sat;
        if (mem_re)
            cmp_idx_reg <= ptr_reg[IDX_BITS-1:0];
        if (state_reg == S_RPT && rd_pend_reg)
        begin
            if (cmp_idx_reg == '0 || rd_data_reg.votes > best_v_reg)
            begin
                best_v_reg <= rd_data_reg.votes;
                best_i_reg <= cmp_idx_reg;
                best_e_reg <= rd_data_reg;
            end
        end
        if (out_load)
        begin
            out_empty_reg <= (count_reg == '0);
            out_slope_reg <= (count_reg == '0) ? '0 : best_e_reg.slope;
            out_icpt_reg  <= (count_reg == '0) ? '0 : best_e_reg.icpt;
            out_votes_reg <= (count_reg == '0) ? '0 : best_e_reg.votes;
            out_index_reg <= (count_reg == '0) ? '0 : best_i_reg;
        end
    end

    assign table_empty    = out_empty_reg;
    assign best_slope     = out_slope_reg;
    assign best_intercept = out_icpt_reg;
    assign best_votes     = out_votes_reg;
    assign best_index     = 7'(out_index_reg);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(best_index))
        else $error("result changed while stalled");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(TABLE_DEPTH))
        else $error("entry count overflow");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall)
        else $error("request taken while busy");

endmodule

@@ rtl/lsivt_div.sv @@
// ============================================================================
// lsivt_div
// Restoring divider, one quotient bit per cycle, for the unsigned slope ratio.
// ============================================================================
module lsivt_div
    import lsivt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [QUO_BITS-1:0]  dividend,
    input  logic [COORD_BITS-1:0] divisor,
    output logic                 done,
    output logic [QUO_BITS-1:0]  quotient
);

    localparam int STEP_BITS = $clog2(QUO_BITS + 1);

    logic [QUO_BITS-1:0]   quo_reg;
    logic [COORD_BITS:0]   rem_reg;
    logic [COORD_BITS-1:0] dsr_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [COORD_BITS+1:0] trial;

    // Shift in the next dividend bit and try the subtraction.
    assign trial = {rem_reg, quo_reg[QUO_BITS-1]} - {2'b00, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_BITS'(QUO_BITS);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[COORD_BITS+1])
            begin
                rem_reg <= trial[COORD_BITS:0];
                quo_reg <= {quo_reg[QUO_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[COORD_BITS-1:0], quo_reg[QUO_BITS-1]};
                quo_reg <= {quo_reg[QUO_BITS-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
